@@ src/mbe_pkg.sv @@
package mbe_pkg;

	localparam int COL_W = 10;
	localparam int ROW_W = 10;
	localparam int COORD_W = 32;
	localparam int ESC_W = 31;
	localparam int ITER_W = 8;
	localparam int COLOR_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_LINE_WIDTH = 1024;
	localparam int DEF_LINE_COUNT = 1024;
	localparam int DEF_FRAC_BITS = 26;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_EDGE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SQ = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INSIDE_COLOR = 3'd6;

	localparam logic [COORD_W-1:0] RST_LEFT_EDGE = 32'hFA00_0000;
	localparam logic [COORD_W-1:0] RST_BOTTOM_EDGE = 32'hFC00_0000;
	localparam logic [COORD_W-1:0] RST_STEP_X = 32'd818400;
	localparam logic [COORD_W-1:0] RST_STEP_Y = 32'd1636801;
	localparam logic [ESC_W-1:0] RST_ESCAPE_SQ = 31'd268435456;
	localparam logic [ITER_W-1:0] RST_MAX_ITER = 8'd20;
	localparam logic [COLOR_W-1:0] RST_INSIDE_COLOR = 7'd30;

	localparam logic [COLOR_W-1:0] PAL_0 = 7'd34;
	localparam logic [COLOR_W-1:0] PAL_1 = 7'd35;
	localparam logic [COLOR_W-1:0] PAL_2 = 7'd36;
	localparam logic [COLOR_W-1:0] PAL_3 = 7'd94;
	localparam logic [COLOR_W-1:0] PAL_4 = 7'd95;
	localparam logic [COLOR_W-1:0] PAL_5 = 7'd96;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_UPD,
		ST_DONE
	} mbe_state_t;

	typedef struct packed {
		logic take_in;
		logic setup;
		logic mul;
		logic upd;
		logic load_out;
	} mbe_cmd_t;

	typedef struct packed {
		logic limit_hit;
		logic escaped;
	} mbe_stat_t;

	function automatic logic [COLOR_W-1:0] palette_code(input logic [2:0] idx);
		logic [COLOR_W-1:0] code;
		case (idx)
			3'd0: code = PAL_0;
			3'd1: code = PAL_1;
			3'd2: code = PAL_2;
			3'd3: code = PAL_3;
			3'd4: code = PAL_4;
			default: code = PAL_5;
		endcase
		return code;
	endfunction

endpackage

@@ src/mbe_intf.sv @@
interface mbe_pix_if import mbe_pkg::*; ();
	logic valid;
	logic ready;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	modport source(output valid, col, row, input ready);
	modport sink(input valid, col, row, output ready);
endinterface

interface mbe_res_if import mbe_pkg::*; ();
	logic valid;
	logic ready;
	logic [ITER_W-1:0] iter_count;
	logic inside_res;
	logic [COLOR_W-1:0] color_code;
	modport source(output valid, iter_count, inside_res, color_code, input ready);
	modport sink(input valid, iter_count, inside_res, color_code, output ready);
endinterface

interface mbe_cfg_if import mbe_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ src/mbe_ctrl.sv @@
module mbe_ctrl import mbe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic out_ready,
	output logic out_valid,
	input mbe_stat_t stat,
	output mbe_cmd_t cmd
);

	mbe_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (stat.limit_hit) begin
					state_d = ST_DONE;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (stat.escaped) begin
					state_d = ST_DONE;
				end else begin
					cmd.upd = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/mbe_dpath.sv @@
module mbe_dpath import mbe_pkg::*; #(
	parameter int LINE_WIDTH = DEF_LINE_WIDTH,
	parameter int LINE_COUNT = DEF_LINE_COUNT,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	mbe_cfg_if.sink cfg,
	input logic [COL_W-1:0] col,
	input logic [ROW_W-1:0] row,
	input mbe_cmd_t cmd,
	output mbe_stat_t stat,
	output logic [ITER_W-1:0] iter_count,
	output logic inside_res,
	output logic [COLOR_W-1:0] color_code
);

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [COORD_W-1:0] r;
		if (v[63:31] == {33{v[63]}}) begin
			r = v[31:0];
		end else if (v[63]) begin
			r = {1'b1, {31{1'b0}}};
		end else begin
			r = {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

	logic signed [COORD_W-1:0] left_edge_q, bottom_edge_q, step_x_q, step_y_q;
	logic [ESC_W-1:0] escape_sq_q;
	logic [ITER_W-1:0] max_iter_q;
	logic [COLOR_W-1:0] inside_color_q;

	logic [COL_W-1:0] col_c, col_q;
	logic [ROW_W-1:0] row_c, row_q;
	logic signed [COORD_W-1:0] cre_q, cim_q, zre_q, zim_q;
	logic signed [63:0] rr_s1, ii_s1, ri_s1;
	logic [ITER_W-1:0] iter_q;
	logic signed [63:0] cre_full, cim_full, re_full, im_full;
	logic signed [63:0] rr_d, ii_d, ri_d;
	logic [63:0] mag, limit;
	logic [11:0] num, m2, m4, m6, m8, m10;
	logic [2:0] pal_idx;
	logic inside_d;
	logic [ITER_W-1:0] iter_count_q;
	logic inside_q;
	logic [COLOR_W-1:0] color_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_edge_q <= RST_LEFT_EDGE;
			bottom_edge_q <= RST_BOTTOM_EDGE;
			step_x_q <= RST_STEP_X;
			step_y_q <= RST_STEP_Y;
			escape_sq_q <= RST_ESCAPE_SQ;
			max_iter_q <= RST_MAX_ITER;
			inside_color_q <= RST_INSIDE_COLOR;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEFT_EDGE: left_edge_q <= cfg.data;
				REG_BOTTOM_EDGE: bottom_edge_q <= cfg.data;
				REG_STEP_X: step_x_q <= cfg.data;
				REG_STEP_Y: step_y_q <= cfg.data;
				REG_ESCAPE_SQ: escape_sq_q <= cfg.data[ESC_W-1:0];
				REG_MAX_ITER: max_iter_q <= cfg.data[ITER_W-1:0];
				REG_INSIDE_COLOR: inside_color_q <= cfg.data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp coordinates to the frame
	always_comb begin
		col_c = (32'(col) > 32'(LINE_WIDTH - 1)) ? COL_W'(LINE_WIDTH - 1) : col;
		row_c = (32'(row) > 32'(LINE_COUNT - 1)) ? ROW_W'(LINE_COUNT - 1) : row;
	end

	assign cre_full = 64'(left_edge_q) + 64'($signed({1'b0, col_q})) * 64'(step_x_q);
	assign cim_full = 64'(bottom_edge_q) + 64'($signed({1'b0, row_q})) * 64'(step_y_q);

	assign rr_d = 64'(zre_q) * 64'(zre_q);
	assign ii_d = 64'(zim_q) * 64'(zim_q);
	assign ri_d = 64'(zre_q) * 64'(zim_q);

	// arithmetic shift is floor division by the power of two
	assign re_full = ((rr_s1 - ii_s1) >>> FRAC_BITS) + 64'(cre_q);
	assign im_full = (ri_s1 >>> (FRAC_BITS - 1)) + 64'(cim_q);

	assign mag = $unsigned(rr_s1) + $unsigned(ii_s1);
	assign limit = 64'(escape_sq_q) << FRAC_BITS;

	assign stat.escaped = (mag >= limit);
	assign stat.limit_hit = (iter_q >= max_iter_q);

	// rounded 5*count/max_iter as a count of threshold compares
	always_comb begin
		num = 12'({iter_q, 3'b000}) + 12'({iter_q, 1'b0}) + 12'(max_iter_q);
		m2 = 12'({max_iter_q, 1'b0});
		m4 = 12'({max_iter_q, 2'b00});
		m8 = 12'({max_iter_q, 3'b000});
		m6 = m4 + m2;
		m10 = m8 + m2;
		pal_idx = 3'(num >= m2) + 3'(num >= m4) + 3'(num >= m6)
			+ 3'(num >= m8) + 3'(num >= m10);
		inside_d = (iter_q == max_iter_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			col_q <= col_c;
			row_q <= row_c;
		end
		if (cmd.setup) begin
			cre_q <= sat32(cre_full);
			cim_q <= sat32(cim_full);
			zre_q <= '0;
			zim_q <= '0;
			iter_q <= '0;
		end
		if (cmd.mul) begin
			rr_s1 <= rr_d;
			ii_s1 <= ii_d;
			ri_s1 <= ri_d;
		end
		if (cmd.upd) begin
			zre_q <= sat32(re_full);
			zim_q <= sat32(im_full);
			iter_q <= iter_q + 1'b1;
		end
		if (cmd.load_out) begin
			iter_count_q <= iter_q;
			inside_q <= inside_d;
			color_q <= inside_d ? inside_color_q : palette_code(pal_idx);
		end
	end

	assign iter_count = iter_count_q;
	assign inside_res = inside_q;
	assign color_code = color_q;

endmodule

@@ src/mandelbrot_escape_time.sv @@
// sequence: the pixel is accepted in ST_IDLE and c is formed in ST_SETUP; each
// iteration then registers the products in ST_MUL and updates z in ST_UPD, and
// ST_DONE loads the result register once it is free. A new pixel is taken only
// after the last result is loaded, and the shared multipliers form one complex
// square per iteration
// reset: configuration registers return to their defaults, controller idles
// and the result register is empty
module mandelbrot_escape_time import mbe_pkg::*; #(
	parameter int LINE_WIDTH = DEF_LINE_WIDTH,
	parameter int LINE_COUNT = DEF_LINE_COUNT,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	mbe_pix_if.sink pixel,
	mbe_res_if.source result,
	mbe_cfg_if.sink cfg
);

	mbe_cmd_t cmd;
	mbe_stat_t stat;

	mbe_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pixel.valid),
		.in_ready(pixel.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.stat(stat),
		.cmd(cmd)
	);

	mbe_dpath #(
		.LINE_WIDTH(LINE_WIDTH),
		.LINE_COUNT(LINE_COUNT),
		.FRAC_BITS(FRAC_BITS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.col(pixel.col),
		.row(pixel.row),
		.cmd(cmd),
		.stat(stat),
		.iter_count(result.iter_count),
		.inside_res(result.inside_res),
		.color_code(result.color_code)
	);

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result.valid || result.ready))
		else $error("result register loaded while an item waits");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> cmd.setup)
		else $error("accepted item not set up");

	a_upd_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> $past(cmd.mul))
		else $error("update without products");

	a_palette: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.inside_res) |->
		(result.color_code == PAL_0 || result.color_code == PAL_1 ||
		 result.color_code == PAL_2 || result.color_code == PAL_3 ||
		 result.color_code == PAL_4 || result.color_code == PAL_5))
		else $error("escaped point with non-palette colour");
`endif

endmodule

@@ test/testbench.sv @@
module testbench;
	import mbe_pkg::*;

	localparam int FRAC = DEF_FRAC_BITS;
	localparam int LINE_W = DEF_LINE_WIDTH;
	localparam int LINE_H = DEF_LINE_COUNT;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -S32_HI - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [COORD_W-1:0] ONE_Q = 32'h0400_0000;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [ESC_W-1:0] esc;
		logic [ITER_W-1:0] max_it;
		logic [COLOR_W-1:0] inside_col;
	} plane_t;

	typedef struct packed {
		logic [ITER_W-1:0] iters;
		logic in_set;
		logic [COLOR_W-1:0] color;
	} pix_res_t;

	logic clk = 1'b0;
	logic arst_n;

	mbe_pix_if pix_if();
	mbe_res_if res_if();
	mbe_cfg_if cfg_if();

	mandelbrot_escape_time DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pix_if),
		.result(res_if),
		.cfg(cfg_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	plane_t plane;
	pix_res_t pending_res[$];
	bit steady = 1'b0;
	int pixels_sent = 0;
	int results_seen = 0;
	int inside_seen = 0;
	int bad_results = 0;
	int planes_used = 0;

	logic [COLOR_W-1:0] palette_codes [6] = '{PAL_0, PAL_1, PAL_2, PAL_3, PAL_4, PAL_5};

	function automatic longint clip32(input longint v);
		if (v > S32_HI)
			return S32_HI;
		if (v < S32_LO)
			return S32_LO;
		return v;
	endfunction

	function automatic pix_res_t escape_time(input plane_t p, input logic [COL_W-1:0] c,
			input logic [ROW_W-1:0] r);
		longint cx, cy, cre, cim, zre, zim, rr, ii, ri;
		longint unsigned lim;
		int n;
		int m;
		int idx;
		bit gone;
		pix_res_t res;
		cx = longint'(c);
		cy = longint'(r);
		if (cx > LINE_W - 1)
			cx = LINE_W - 1;
		if (cy > LINE_H - 1)
			cy = LINE_H - 1;
		cre = clip32(longint'($signed(p.left)) + cx * longint'($signed(p.dx)));
		cim = clip32(longint'($signed(p.bottom)) + cy * longint'($signed(p.dy)));
		lim = longint'(p.esc) << FRAC;
		zre = 0;
		zim = 0;
		n = 0;
		m = int'(p.max_it);
		gone = 1'b0;
		while (!gone && n < m) begin
			rr = zre * zre;
			ii = zim * zim;
			ri = zre * zim;
			if ($unsigned(rr) + $unsigned(ii) >= lim) begin
				gone = 1'b1;
			end else begin
				// floor division by a power of two is an arithmetic shift
				zre = clip32(((rr - ii) >>> FRAC) + cre);
				zim = clip32((ri >>> (FRAC - 1)) + cim);
				n++;
			end
		end
		res.iters = n[ITER_W-1:0];
		res.in_set = (n == m);
		if (res.in_set) begin
			res.color = p.inside_col;
		end else begin
			// round half up of 5*n/m
			idx = (10 * n + m) / (2 * m);
			if (idx > 5)
				idx = 5;
			res.color = palette_codes[idx];
		end
		return res;
	endfunction

	task automatic send_pixel(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.col <= c;
		pix_if.row <= r;
		do @(posedge clk); while (!pix_if.ready);
		pending_res.push_back(escape_time(plane, c, r));
		pixels_sent++;
	endtask

	task automatic wait_drained();
		pix_if.valid <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_LEFT_EDGE: plane.left = data;
			REG_BOTTOM_EDGE: plane.bottom = data;
			REG_STEP_X: plane.dx = data;
			REG_STEP_Y: plane.dy = data;
			REG_ESCAPE_SQ: plane.esc = data[ESC_W-1:0];
			REG_MAX_ITER: plane.max_it = data[ITER_W-1:0];
			REG_INSIDE_COLOR: plane.inside_col = data[COLOR_W-1:0];
			default: ;
		endcase
	endtask

	// only called with nothing in flight
	task automatic load_plane(input plane_t p);
		if ($urandom_range(0, 1))
			set_reg(REG_UNUSED, $urandom());
		set_reg(REG_LEFT_EDGE, p.left);
		set_reg(REG_BOTTOM_EDGE, p.bottom);
		set_reg(REG_STEP_X, p.dx);
		set_reg(REG_STEP_Y, p.dy);
		// upper bits of the narrow registers carry junk
		set_reg(REG_ESCAPE_SQ, {1'($urandom()), p.esc});
		set_reg(REG_MAX_ITER, {24'($urandom()), p.max_it});
		set_reg(REG_INSIDE_COLOR, {25'($urandom()), p.inside_col});
		cfg_if.valid <= 1'b0;
		planes_used++;
	endtask

	function automatic plane_t random_plane();
		plane_t p;
		if ($urandom_range(0, 3) == 0) begin
			p.left = $urandom();
			p.bottom = $urandom();
			p.dx = $urandom();
			p.dy = $urandom();
			p.esc = ESC_W'($urandom());
			p.max_it = ITER_W'($urandom());
			p.inside_col = COLOR_W'($urandom());
		end else begin
			// window around the set, from -2.25..-0.75 and -2.0..-1.0
			p.left = 32'hF700_0000 + $urandom_range(0, 32'h0600_0000);
			p.bottom = 32'hF800_0000 + $urandom_range(0, 32'h0400_0000);
			p.dx = $urandom_range(16384, 524288);
			p.dy = $urandom_range(16384, 524288);
			if ($urandom_range(0, 3) == 0)
				p.dx = -p.dx;
			if ($urandom_range(0, 3) == 0)
				p.dy = -p.dy;
			p.esc = ($urandom_range(0, 3) == 0) ? ESC_W'($urandom()) : 31'h1000_0000;
			p.max_it = ITER_W'($urandom_range(1, 40));
			p.inside_col = COLOR_W'($urandom_range(0, 127));
		end
		if ($urandom_range(0, 7) == 0)
			p.max_it = ITER_W'($urandom_range(41, 255));
		else if ($urandom_range(0, 15) == 0)
			p.max_it = '0;
		return p;
	endfunction

	// result side: random stall per item, then compare with the oldest prediction
	initial begin
		int stall;
		pix_res_t got;
		pix_res_t want;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (res_if.valid !== 1'b1);
			got.iters = res_if.iter_count;
			got.in_set = res_if.inside_res;
			got.color = res_if.color_code;
			results_seen++;
			if (pending_res.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result: iter %0d inside %0d color %0d",
						got.iters, got.in_set, got.color);
			end else begin
				want = pending_res.pop_front();
				if (got.in_set === 1'b1)
					inside_seen++;
				if (got.iters !== want.iters || got.in_set !== want.in_set ||
						got.color !== want.color) begin
					bad_results++;
					if (bad_results <= 10)
						$display("result %0d: iter %0d/%0d inside %0d/%0d color %0d/%0d (exp/got)",
							results_seen, want.iters, got.iters, want.in_set, got.in_set,
							want.color, got.color);
				end
			end
		end
	end

	task automatic test_reset_values();
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd82, 10'd41);
		send_pixel(10'd123, 10'd41);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
		wait_drained();
	endtask

	task automatic test_saturating_corners();
		plane_t p;
		p = {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
			8'd255, 7'd127};
		load_plane(p);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		wait_drained();
		// c near (3.98, +-3.98): the imaginary part of z saturates on the next square
		p = {32'd267093279, 32'd267093279, 32'd0, 32'd0, 31'h7FFF_FFFF, 8'd10, 7'd0};
		load_plane(p);
		send_pixel(10'd0, 10'd0);
		wait_drained();
		p.bottom = -32'd267093279;
		load_plane(p);
		send_pixel(10'd1023, 10'd1023);
		wait_drained();
	endtask

	task automatic test_iteration_limits();
		plane_t p;
		// zero escape radius: every point escapes at once
		p = {RST_LEFT_EDGE, RST_BOTTOM_EDGE, RST_STEP_X, RST_STEP_Y, 31'd0, RST_MAX_ITER,
			7'd127};
		load_plane(p);
		send_pixel(10'd82, 10'd41);
		wait_drained();
		// zero limit: no iteration, reported inside
		p.esc = RST_ESCAPE_SQ;
		p.max_it = 8'd0;
		p.inside_col = 7'd0;
		load_plane(p);
		send_pixel(10'd82, 10'd41);
		send_pixel(10'd1023, 10'd1023);
		wait_drained();
		// c = 2.5 escapes after one step: inside with limit 1, outside with limit 2
		p = {ONE_Q * 5 / 2, 32'd0, 32'd0, 32'd0, RST_ESCAPE_SQ, 8'd1, 7'd77};
		set_reg(REG_UNUSED, 32'hFFFF_FFFF);
		load_plane(p);
		send_pixel(10'd5, 10'd5);
		wait_drained();
		p.max_it = 8'd2;
		load_plane(p);
		send_pixel(10'd5, 10'd5);
		wait_drained();
	endtask

	task automatic test_random_planes();
		logic [COL_W-1:0] c;
		logic [ROW_W-1:0] r;
		for (int ph = 0; ph < 9; ph++) begin
			load_plane(random_plane());
			steady = (ph == 3);
			for (int k = 0; k < 55; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					c = COL_W'($urandom_range(0, 1023));
					r = ROW_W'($urandom_range(0, 1023));
				end else begin
					c = COL_W'($urandom_range(0, 255));
					r = ROW_W'($urandom_range(0, 255));
				end
				send_pixel(c, r);
				// hold the pixels back until the block has emptied
				if (ph == 5 && k == 25)
					wait_drained();
			end
			wait_drained();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		pix_if.valid <= 1'b0;
		pix_if.col <= '0;
		pix_if.row <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		plane = {RST_LEFT_EDGE, RST_BOTTOM_EDGE, RST_STEP_X, RST_STEP_Y, RST_ESCAPE_SQ,
			RST_MAX_ITER, RST_INSIDE_COLOR};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_saturating_corners();
		test_iteration_limits();
		test_random_planes();

		wait_drained();
		repeat (2 * 255 + 10) @(posedge clk);
		if (pending_res.size() != 0) begin
			bad_results++;
			$display("%0d predicted results never arrived", pending_res.size());
		end
		$display("%0d pixels over %0d view settings, %0d results checked, %0d inside",
			pixels_sent, planes_used, results_seen, inside_seen);
		$display("saturating corners, zero radius, zero and last-step limits, random windows");
		if (bad_results == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
src/mbe_pkg.sv
src/mbe_intf.sv
src/mbe_ctrl.sv
src/mbe_dpath.sv
src/mandelbrot_escape_time.sv
test/testbench.sv
